>>> hw/rtl/iodbmt_pkg.sv
// Types and constants shared by the I/O doorbell match table.
// No dependencies.
`timescale 1ns / 1ps

package iodbmt_pkg;

  localparam logic [1:0] FUNC_ASSIGN   = 2'd0;
  localparam logic [1:0] FUNC_DEASSIGN = 2'd1;
  localparam logic [1:0] FUNC_ACCESS   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_EXIST = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [3:0] LEN_B = 4'd1;
  localparam logic [3:0] LEN_W = 4'd2;
  localparam logic [3:0] LEN_D = 4'd4;
  localparam logic [3:0] LEN_Q = 4'd8;

  typedef struct packed {
    logic [15:0] ev;
    logic [63:0] addr;
    logic [63:0] data;
    logic [3:0]  len;
    logic        space;
    logic        wild;
  } entry_t;

  typedef struct packed {
    logic conflict;
    logic hit;
    logic ev_eq;
  } match_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/iodbmt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module iodbmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/iodbmt_cmp.sv
// Entry compare unit: checks one stored entry against the request.
// Depends on iodbmt_pkg.
`timescale 1ns / 1ps

module iodbmt_cmp (
  input  iodbmt_pkg::entry_t ent,
  input  iodbmt_pkg::entry_t req,
  output iodbmt_pkg::match_t flags
);
  import iodbmt_pkg::*;

  logic addr_eq;
  logic space_eq;
  logic data_eq;

  assign addr_eq  = (ent.addr == req.addr);
  assign space_eq = (ent.space == req.space);
  assign data_eq  = (ent.data == req.data);

  assign flags.ev_eq    = (ent.ev == req.ev);
  assign flags.conflict = flags.ev_eq && addr_eq && space_eq &&
                          (ent.wild || req.wild || data_eq);
  // access: entry length covers the access size, size 0 matches anything
  assign flags.hit      = space_eq && addr_eq && (ent.len >= req.len) &&
                          (ent.wild || data_eq);

endmodule

>>> hw/rtl/io_doorbell_match_table_top.sv
// I/O doorbell match table top: sequencer, entry count and result registers.
// Depends on iodbmt_pkg, iodbmt_ram, iodbmt_cmp.
`timescale 1ns / 1ps

// One item at a time: busy is high from the accepting edge until the result
// strobe. The result is on out_* for exactly one cycle with out_valid high and
// cannot be held off. Entries live in one RAM with a single registered read
// port, walked one entry per cycle. Reads, unknown funcs, assigns rejected as
// invalid or full, and deassigns or accesses on an empty table go straight to
// the result; a scan stops at a conflict, match, hit or the last entry; a
// deassign that finds its entry moves every later entry down one place to
// close the gap; an assign that appends adds a write state. The table starts
// empty after reset with no clearing pass.
module io_doorbell_match_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_event_id,
  input  logic [63:0] in_address,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_value,
  input  logic        in_is_pio,
  input  logic        in_match_data,
  input  logic        in_is_read,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic [15:0] out_hit_event_id,
  output logic        out_read_value
);
  import iodbmt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [1:0]      func_r, func_nxt;
  entry_t          req_r, req_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            hit_r, hit_nxt;
  logic [15:0]     hev_r, hev_nxt;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;
  match_t          flags;

  logic [64:0]     end_addr;
  logic            len_ok;
  logic            last;
  logic            more;

  iodbmt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r[IW-1:0]),
    .rdata(ram_rdata)
  );

  iodbmt_cmp u_cmp (
    .ent  (ram_rdata),
    .req  (req_r),
    .flags(flags)
  );

  assign end_addr = {1'b0, in_address} + {61'd0, in_length};
  assign len_ok   = (in_length == LEN_B) || (in_length == LEN_W) ||
                    (in_length == LEN_D) || (in_length == LEN_Q);
  assign last     = ((CW'(cmp_idx_r) + CW'(1)) == count_r);
  assign more     = (idx_r < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    func_r    <= func_nxt;
    req_r     <= req_nxt;
    status_r  <= status_nxt;
    hit_r     <= hit_nxt;
    hev_r     <= hev_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    func_nxt    = func_r;
    req_nxt     = req_r;
    status_nxt  = status_r;
    hit_nxt     = hit_r;
    hev_nxt     = hev_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[IW-1:0];
    ram_wdata   = req_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt       = in_func;
          req_nxt.ev     = in_event_id;
          req_nxt.addr   = in_address;
          req_nxt.len    = in_length;
          req_nxt.space  = in_is_pio;
          req_nxt.wild   = !in_match_data;
          req_nxt.data   = (in_func == FUNC_ASSIGN && !in_match_data) ? 64'd0 : in_value;
          status_nxt     = ST_OK;
          hit_nxt        = 1'b0;
          hev_nxt        = 16'd0;
          idx_nxt        = '0;
          state_nxt      = S_DONE;
          case (in_func)
            FUNC_ASSIGN: begin
              if (end_addr[64] || !len_ok) begin
                status_nxt = ST_INVAL;
              end else if (count_r == CW'(ENTRIES)) begin
                status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                state_nxt = S_WRITE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FUNC_DEASSIGN: begin
              if (count_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            FUNC_ACCESS: begin
              if (!in_is_read && count_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              status_nxt = ST_INVAL;
            end
          endcase
        end
      end

      S_SCAN: begin
        cmp_vld_nxt = more;
        cmp_idx_nxt = idx_r[IW-1:0];
        if (more) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (cmp_vld_r) begin
          case (func_r)
            FUNC_ASSIGN: begin
              if (flags.conflict) begin
                status_nxt = ST_EXIST;
                state_nxt  = S_DONE;
              end else if (last) begin
                state_nxt = S_WRITE;
              end
            end
            FUNC_DEASSIGN: begin
              if (flags.ev_eq) begin
                idx_nxt     = CW'(cmp_idx_r) + CW'(1);
                cmp_vld_nxt = 1'b0;
                state_nxt   = S_SHIFT;
              end else if (last) begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              if (flags.hit) begin
                hit_nxt   = 1'b1;
                hev_nxt   = ram_rdata.ev;
                state_nxt = S_DONE;
              end else if (last) begin
                state_nxt = S_DONE;
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read entry i, write it back at i - 1 on the next cycle
        cmp_vld_nxt = more;
        cmp_idx_nxt = idx_r[IW-1:0];
        if (more) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (cmp_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_r - IW'(1);
          ram_wdata = ram_rdata;
        end else if (!more) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = count_r[IW-1:0];
        ram_wdata = req_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_status       = status_r;
  assign out_hit          = hit_r;
  assign out_hit_event_id = hev_r;
  assign out_read_value   = 1'b0;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_count_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid)
    else $error("entry count changed without a result");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_status == ST_OK))
    else $error("hit reported with nonzero status");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("result not followed by idle");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for io_doorbell_match_table_top.
// Predicts each result from its own table model and compares at the result strobe.
// Depends on iodbmt_pkg and the io_doorbell_match_table_top RTL.
`timescale 1ns / 1ps

module testbench;
  import iodbmt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] FUNC_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] event_id;
    logic [63:0] address;
    logic [3:0]  length;
    logic [63:0] value;
    logic        is_pio;
    logic        match_data;
    logic        is_read;
  } door_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [15:0] hit_event_id;
    logic        read_value;
  } door_resp_t;

  typedef struct packed {
    logic [15:0] ev;
    logic [63:0] addr;
    logic [63:0] data;
    logic [3:0]  len;
    logic        space;
    logic        wild;
  } door_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [15:0] in_event_id = '0;
  logic [63:0] in_address = '0;
  logic [3:0]  in_length = '0;
  logic [63:0] in_value = '0;
  logic        in_is_pio = 1'b0;
  logic        in_match_data = 1'b0;
  logic        in_is_read = 1'b0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_hit;
  logic [15:0] out_hit_event_id;
  logic        out_read_value;

  door_req_t   pending_reqs[$];
  door_resp_t  expected_results[$];
  door_entry_t door_table[$];
  door_req_t   active_req;
  int          issued_count = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  logic [15:0] ev_pool[6];
  logic [63:0] addr_pool[6];
  logic [63:0] data_pool[4];

  io_doorbell_match_table_top #(.ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_event_id(in_event_id), .in_address(in_address),
    .in_length(in_length), .in_value(in_value), .in_is_pio(in_is_pio),
    .in_match_data(in_match_data), .in_is_read(in_is_read),
    .out_valid(out_valid), .out_status(out_status), .out_hit(out_hit),
    .out_hit_event_id(out_hit_event_id), .out_read_value(out_read_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Applies one item to the table model and returns the result it must produce.
  function automatic door_resp_t apply_request(door_req_t req);
    door_resp_t  rsp;
    door_entry_t ent;
    logic [64:0] span;
    bit          found;
    rsp.status = ST_OK;
    rsp.hit = 1'b0;
    rsp.hit_event_id = 16'd0;
    rsp.read_value = 1'b0;
    found = 1'b0;
    case (req.func)
      FUNC_ASSIGN: begin
        span = {1'b0, req.address} + {61'd0, req.length};
        ent.ev = req.event_id;
        ent.addr = req.address;
        ent.len = req.length;
        ent.space = req.is_pio;
        ent.wild = !req.match_data;
        ent.data = ent.wild ? 64'd0 : req.value;
        if (span[64]) begin
          rsp.status = ST_INVAL;
        end else if (req.length != LEN_B && req.length != LEN_W &&
                     req.length != LEN_D && req.length != LEN_Q) begin
          rsp.status = ST_INVAL;
        end else if (door_table.size() >= TABLE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          foreach (door_table[i]) begin
            if (door_table[i].ev == ent.ev && door_table[i].addr == ent.addr &&
                door_table[i].space == ent.space &&
                (door_table[i].wild || ent.wild || door_table[i].data == ent.data))
              found = 1'b1;
          end
          if (found) rsp.status = ST_EXIST;
          else door_table.push_back(ent);
        end
      end
      FUNC_DEASSIGN: begin
        for (int i = 0; i < door_table.size() && !found; i++) begin
          if (door_table[i].ev == req.event_id) begin
            door_table.delete(i);
            found = 1'b1;
          end
        end
      end
      FUNC_ACCESS: begin
        if (!req.is_read) begin
          for (int i = 0; i < door_table.size() && !found; i++) begin
            if (door_table[i].space == req.is_pio && door_table[i].addr == req.address &&
                door_table[i].len >= req.length &&
                (door_table[i].wild || door_table[i].data == req.value)) begin
              found = 1'b1;
              rsp.hit = 1'b1;
              rsp.hit_event_id = door_table[i].ev;
            end
          end
        end
      end
      default: rsp.status = ST_INVAL;
    endcase
    return rsp;
  endfunction

  task automatic add_req(input logic [1:0] func, input logic [15:0] ev,
                         input logic [63:0] addr, input logic [3:0] len,
                         input logic [63:0] val, input logic pio,
                         input logic md, input logic rd);
    door_req_t req;
    req.func = func;
    req.event_id = ev;
    req.address = addr;
    req.length = len;
    req.value = val;
    req.is_pio = pio;
    req.match_data = md;
    req.is_read = rd;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: when the slot is free, present the next item or, at random, leave a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results.push_back(apply_request(active_req));
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 &&
            ((issued_count >= 300 && issued_count < 500) || $urandom_range(99) >= 9)) begin
          active_req = pending_reqs.pop_front();
          issued_count++;
          in_func <= active_req.func;
          in_event_id <= active_req.event_id;
          in_address <= active_req.address;
          in_length <= active_req.length;
          in_value <= active_req.value;
          in_is_pio <= active_req.is_pio;
          in_match_data <= active_req.match_data;
          in_is_read <= active_req.is_read;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    door_resp_t exp_rsp;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %h hit %h ev %h", $time,
                 out_status, out_hit, out_hit_event_id);
        fail_count++;
      end else begin
        exp_rsp = expected_results.pop_front();
        if (out_status !== exp_rsp.status) begin
          $display("%0t: status expected %h actual %h", $time, exp_rsp.status, out_status);
          fail_count++;
        end
        if (out_hit !== exp_rsp.hit) begin
          $display("%0t: hit expected %h actual %h", $time, exp_rsp.hit, out_hit);
          fail_count++;
        end
        if (out_hit_event_id !== exp_rsp.hit_event_id) begin
          $display("%0t: hit_event_id expected %h actual %h", $time,
                   exp_rsp.hit_event_id, out_hit_event_id);
          fail_count++;
        end
        if (out_read_value !== exp_rsp.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   exp_rsp.read_value, out_read_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] pat;
    logic [1:0]  func;
    logic [3:0]  len;
    int          pick;
    bit          fill_phase;
    pat = 64'h5555_5555_5555_5555;

    // directed: empty table, bad codes, overflow, conflicts, length and data matching
    add_req(FUNC_ACCESS, 16'h0, 64'h0, 4'd0, 64'h0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_UNDEF, 16'hFFFF, '1, 4'hF, '1, 1'b1, 1'b1, 1'b1);
    add_req(FUNC_DEASSIGN, 16'h1234, 64'h0, 4'd0, 64'h0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_ASSIGN, 16'h1, 64'h100, 4'd0, 64'h0, 1'b0, 1'b1, 1'b0);
    add_req(FUNC_ASSIGN, 16'h1, 64'h100, 4'd3, 64'h0, 1'b0, 1'b1, 1'b0);
    add_req(FUNC_ASSIGN, 16'h1, '1, 4'hF, 64'h0, 1'b0, 1'b1, 1'b0);
    add_req(FUNC_ASSIGN, 16'h1, 64'hFFFF_FFFF_FFFF_FFF8, LEN_Q, 64'h0, 1'b0, 1'b1, 1'b0);
    add_req(FUNC_ASSIGN, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF7, LEN_Q, '1, 1'b1, 1'b1, 1'b0);
    add_req(FUNC_ASSIGN, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF7, LEN_Q, '1, 1'b1, 1'b1, 1'b0);
    add_req(FUNC_ASSIGN, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF7, LEN_Q, pat, 1'b1, 1'b1, 1'b0);
    add_req(FUNC_ASSIGN, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF7, LEN_D, 64'h0, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_ASSIGN, 16'h0, 64'h0, LEN_B, '1, 1'b0, 1'b0, 1'b1);
    add_req(FUNC_ACCESS, 16'h0, 64'h0, 4'd1, rand64(), 1'b0, 1'b1, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'h0, 4'd2, rand64(), 1'b0, 1'b0, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'h0, 4'd0, rand64(), 1'b0, 1'b0, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'h0, 4'd1, 64'h0, 1'b0, 1'b0, 1'b1);
    add_req(FUNC_ACCESS, 16'h0, 64'h0, 4'd1, 64'h0, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'hFFFF_FFFF_FFFF_FFF7, 4'd8, '1, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'hFFFF_FFFF_FFFF_FFF7, 4'd8, 64'h0, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_DEASSIGN, 16'hFFFF, 64'h0, 4'd0, 64'h0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'hFFFF_FFFF_FFFF_FFF7, 4'd4, '1, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'hFFFF_FFFF_FFFF_FFF7, 4'd9, pat, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_ACCESS, 16'h0, 64'hFFFF_FFFF_FFFF_FFF7, 4'd4, pat, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_DEASSIGN, 16'h0, 64'h0, 4'd0, 64'h0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_DEASSIGN, 16'hFFFF, 64'h0, 4'd0, 64'h0, 1'b0, 1'b0, 1'b0);

    // small pools so conflicts, hits and removals happen often
    ev_pool[0] = 16'h0000;
    ev_pool[1] = 16'hFFFF;
    addr_pool[0] = 64'h0;
    addr_pool[1] = 64'hFFFF_FFFF_FFFF_FFF8;
    addr_pool[2] = {48'h0, 16'($urandom)};
    addr_pool[3] = {60'h0, 4'($urandom)};
    addr_pool[4] = rand64();
    addr_pool[5] = rand64();
    for (int i = 2; i < 6; i++) ev_pool[i] = 16'($urandom);
    data_pool[0] = 64'h0;
    data_pool[1] = '1;
    data_pool[2] = rand64();
    data_pool[3] = {56'h0, 8'($urandom)};

    // alternate fill-heavy and drain-heavy stretches so the table reaches full and empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      fill_phase = ((n / 100) % 2) == 0;
      if ($urandom_range(99) < 12) begin
        add_req(2'($urandom), 16'($urandom), rand64(), 4'($urandom), rand64(),
                1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) func = FUNC_UNDEF;
        else if (pick < (fill_phase ? 57 : 22)) func = FUNC_ASSIGN;
        else if (pick < (fill_phase ? 67 : 62)) func = FUNC_DEASSIGN;
        else func = FUNC_ACCESS;
        if (func == FUNC_ASSIGN)
          len = ($urandom_range(99) < 88) ? 4'(1 << $urandom_range(3)) : 4'($urandom);
        else
          len = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom);
        add_req(func, ev_pool[$urandom_range(5)], addr_pool[$urandom_range(5)], len,
                data_pool[$urandom_range(3)], 1'($urandom_range(99) < 50),
                1'($urandom_range(99) < 60),
                1'($urandom_range(99) < ((func == FUNC_ACCESS) ? 25 : 50)));
      end
    end

    @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
